// ----- hw/rtl/gpsc_pkg.sv -----
package gpsc_pkg;

  // Item kinds. The spare code is handled like a report.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // Graph sizes.
  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 2048;

  localparam int KindW   = 2;
  localparam int NodeW   = $clog2(MaxNodes);
  localparam int CfgW    = 11;
  localparam int CountW  = 32;
  localparam int PlenW   = 11;

  // One classified command, as it travels from the front to the back.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             err;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

endpackage

// ----- hw/rtl/gpsc_front.sv -----
module gpsc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [10:0]              cfg_wr_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [1:0]               in_tuser,
  input  logic [23:0]              in_tdata,
  output logic                     cmd_valid,
  input  logic                     cmd_ready,
  output gpsc_pkg::cmd_t           cmd
);
  import gpsc_pkg::*;

  logic [CfgW-1:0] node_count_r;
  logic [CfgW-1:0] active_n;
  logic [NodeW-1:0] a, b;
  logic            range_err;

  // Node count register; values above the node limit act as the limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CfgW'(MaxNodes);
    end else if (cfg_wr_en) begin
      node_count_r <= cfg_wr_data;
    end
  end

  assign active_n = (node_count_r > CfgW'(MaxNodes)) ? CfgW'(MaxNodes) : node_count_r;
  assign a = in_tdata[NodeW-1:0];
  assign b = in_tdata[2*NodeW-1:NodeW];
  assign range_err = ({1'b0, a} >= active_n) || ({1'b0, b} >= active_n);

  // Classification only: queue lives in the top level.
  assign in_tready = cmd_ready;
  assign cmd_valid = in_tvalid;
  always_comb begin
    cmd.kind   = (in_tuser == KIND_ADD || in_tuser == KIND_QUERY) ? in_tuser : KIND_REPORT;
    cmd.err    = (in_tuser == KIND_ADD || in_tuser == KIND_QUERY) && range_err;
    cmd.node_a = a;
    cmd.node_b = b;
  end
endmodule

// ----- hw/rtl/gpsc_queue.sv -----
module gpsc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  gpsc_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output gpsc_pkg::cmd_t rd_data
);
  import gpsc_pkg::*;

  // Two-entry queue between the front and the back.
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

// ----- hw/rtl/gpsc_back.sv -----
module gpsc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  gpsc_pkg::cmd_t cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [47:0]    out_tdata
);
  import gpsc_pkg::*;

  localparam int NW  = $clog2(MaxNodes);
  localparam int EW  = $clog2(MaxEdges);
  localparam int ETW = $clog2(MaxEdges + 1);
  localparam int DW  = $clog2(MaxNodes + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_VCLR, S_TOP, S_HEAD, S_EDGE, S_EDGE2,
    S_EDGE3, S_CNT_RD, S_CNT_LD, S_CNT_WR, S_OUT
  } state_t;

  // Memories.
  logic [EW-1:0]    head_mem  [MaxNodes];
  logic [EW-1:0]    tail_mem  [MaxNodes];
  logic             lvalid_mem[MaxNodes];
  logic [EW-1:0]    enext_mem [MaxEdges];
  logic [NW-1:0]    etgt_mem  [MaxEdges];
  logic             elast_mem [MaxEdges];
  logic [CountW-1:0] vcnt_mem [MaxNodes];
  logic             vis_mem   [MaxNodes];
  logic [NW-1:0]    snode_mem [MaxNodes];
  logic [EW-1:0]    scur_mem  [MaxNodes];
  logic             scv_mem   [MaxNodes];

  state_t            state_r;
  logic [NW:0]       sweep_r;
  logic [NodeW-1:0]  node_a_r;
  logic [NodeW-1:0]  node_b_r;
  logic [ETW-1:0]    etotal_r;
  logic [CountW-1:0] rmax_r;
  logic [DW-1:0]     depth_r;
  logic [DW-1:0]     idx_r;
  logic [PlenW-1:0]  plen_r;
  logic              err_r;
  logic [NW-1:0]     u_r;
  logic [EW-1:0]     cur_r;
  logic              cv_r;
  logic [EW-1:0]     tail_rd_r;
  logic              lv_rd_r;
  logic [NW-1:0]     tgt_rd_r;
  logic [EW-1:0]     nxt_rd_r;
  logic              last_rd_r;
  logic              vis_rd_r;
  logic [EW-1:0]     head_rd_r;
  logic              hv_rd_r;
  logic [CountW-1:0] cnt_rd_r;
  logic [NW-1:0]     cnt_node_r;

  logic [NW-1:0] a_n, b_n, top_i;
  assign a_n   = node_a_r;
  assign b_n   = node_b_r;
  assign top_i = NW'(depth_r - DW'(1));

  assign cmd_ready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  // Result fields from low to high: maximum, path length, error.
  assign out_tdata  = {4'd0, err_r, plen_r, rmax_r};

  // Sequencer: one item at a time, memory reads are registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      sweep_r  <= '0;
      etotal_r <= '0;
      rmax_r   <= '0;
      depth_r  <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          // Clear valid bits, counters and marks, one node a cycle.
          lvalid_mem[sweep_r[NW-1:0]] <= 1'b0;
          vcnt_mem[sweep_r[NW-1:0]]   <= '0;
          vis_mem[sweep_r[NW-1:0]]    <= 1'b0;
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (NW+1)'(MaxNodes - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid) begin
            node_a_r <= cmd.node_a;
            node_b_r <= cmd.node_b;
            err_r    <= cmd.err;
            plen_r   <= '0;
            if (cmd.err || cmd.kind == KIND_REPORT) begin
              state_r <= S_OUT;
            end else if (cmd.kind == KIND_ADD) begin
              if (etotal_r >= ETW'(MaxEdges)) begin
                err_r   <= 1'b1;
                state_r <= S_OUT;
              end else begin
                state_r <= S_ADD_RD;
              end
            end else begin
              sweep_r <= '0;
              state_r <= S_VCLR;
            end
          end
        end
        S_ADD_RD: begin
          tail_rd_r <= tail_mem[a_n];
          lv_rd_r   <= lvalid_mem[a_n];
          state_r   <= S_ADD_WR;
        end
        S_ADD_WR: begin
          etgt_mem[EW'(etotal_r)]  <= b_n;
          elast_mem[EW'(etotal_r)] <= 1'b1;
          enext_mem[EW'(etotal_r)] <= '0;
          if (lv_rd_r) begin
            enext_mem[tail_rd_r] <= EW'(etotal_r);
            elast_mem[tail_rd_r] <= 1'b0;
          end else begin
            head_mem[a_n]   <= EW'(etotal_r);
            lvalid_mem[a_n] <= 1'b1;
          end
          tail_mem[a_n] <= EW'(etotal_r);
          etotal_r <= etotal_r + 1'b1;
          state_r  <= S_OUT;
        end
        S_VCLR: begin
          // Clear visited marks, then fetch the start node's list head.
          vis_mem[sweep_r[NW-1:0]] <= 1'b0;
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (NW+1)'(MaxNodes - 1)) begin
            u_r       <= a_n;
            head_rd_r <= head_mem[a_n];
            hv_rd_r   <= lvalid_mem[a_n];
            depth_r   <= '0;
            state_r   <= S_HEAD;
          end
        end
        S_HEAD: begin
          // Push u_r with the list head fetched beforehand.
          snode_mem[NW'(depth_r)] <= u_r;
          scur_mem[NW'(depth_r)]  <= head_rd_r;
          scv_mem[NW'(depth_r)]   <= hv_rd_r;
          vis_mem[u_r] <= 1'b1;
          depth_r <= depth_r + 1'b1;
          state_r <= S_TOP;
        end
        S_TOP: begin
          if (depth_r == '0) begin
            state_r <= S_OUT;
          end else begin
            u_r   <= snode_mem[top_i];
            cur_r <= scur_mem[top_i];
            cv_r  <= scv_mem[top_i];
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (u_r == b_n) begin
            plen_r  <= PlenW'(depth_r);
            idx_r   <= '0;
            state_r <= S_CNT_RD;
          end else if (!cv_r) begin
            vis_mem[u_r] <= 1'b0;
            depth_r <= depth_r - 1'b1;
            state_r <= S_TOP;
          end else begin
            tgt_rd_r  <= etgt_mem[cur_r];
            nxt_rd_r  <= enext_mem[cur_r];
            last_rd_r <= elast_mem[cur_r];
            state_r   <= S_EDGE2;
          end
        end
        S_EDGE2: begin
          // Advance the cursor and fetch the target's mark and list head.
          cv_r  <= !last_rd_r;
          cur_r <= nxt_rd_r;
          scv_mem[top_i]  <= !last_rd_r;
          scur_mem[top_i] <= nxt_rd_r;
          vis_rd_r  <= vis_mem[tgt_rd_r];
          head_rd_r <= head_mem[tgt_rd_r];
          hv_rd_r   <= lvalid_mem[tgt_rd_r];
          state_r   <= S_EDGE3;
        end
        S_EDGE3: begin
          // Descend into an unvisited target, otherwise try the next edge.
          if (!vis_rd_r && depth_r < DW'(MaxNodes)) begin
            u_r     <= tgt_rd_r;
            state_r <= S_HEAD;
          end else begin
            state_r <= S_EDGE;
          end
        end
        S_CNT_RD: begin
          if (idx_r == depth_r) begin
            state_r <= S_OUT;
          end else begin
            cnt_node_r <= snode_mem[NW'(idx_r)];
            state_r    <= S_CNT_LD;
          end
        end
        S_CNT_LD: begin
          cnt_rd_r <= vcnt_mem[cnt_node_r];
          state_r  <= S_CNT_WR;
        end
        S_CNT_WR: begin
          if (cnt_rd_r != '1) begin
            vcnt_mem[cnt_node_r] <= cnt_rd_r + 1'b1;
            if (cnt_rd_r + 1'b1 > rmax_r) rmax_r <= cnt_rd_r + 1'b1;
          end else if (cnt_rd_r > rmax_r) begin
            rmax_r <= cnt_rd_r;
          end
          idx_r   <= idx_r + 1'b1;
          state_r <= S_CNT_RD;
        end
        S_OUT: begin
          if (out_tready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/graph_path_search_counter.sv -----
// Steps: an add reads the list tail, then links in the new edge; a report or rejected
// item goes straight to the result. A query first clears the visited marks, then
// searches depth first edge by edge, and bumps the count of each node on the found path.
// The back end takes one item at a time; the front queue holds two more.
// Reset (rst_n, synchronous): a pass over all nodes clears lists, counters and
// marks; the back end takes no item until it finishes.
module graph_path_search_counter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // node_a, node_b, zero fill
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // max_count, path_length, error, zero fill
);
  import gpsc_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  gpsc_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_tvalid, .in_tready, .in_tuser,
    .in_tdata, .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  gpsc_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  gpsc_back u_back (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_tvalid, .out_tready, .out_tdata
  );
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpsc_pkg::*;

  localparam int NODES = 1024;
  localparam int EDGES = 2048;
  localparam int SMALL_SPAN = 6;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE = 40;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // node_a, node_b, zero fill
  logic [1:0]  in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // max_count, path_length, error, zero fill

  graph_path_search_counter uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct {
    logic [CountW-1:0] max_count;
    logic [PlenW-1:0]  path_length;
    logic              error;
  } answer_t;

  // A directed stimulus row; cfg below zero means no register write first.
  typedef struct {
    int cfg;
    int kind;
    int a;
    int b;
    bit typed;
    int max_count;
    int path_length;
    int error;
  } row_t;

  answer_t answer_q[$];

  // Mirror of the graph, the counters and the search stack.
  int unsigned   node_limit;
  int unsigned   head_edge [NODES];
  int unsigned   tail_edge [NODES];
  bit            list_live [NODES];
  int unsigned   next_edge [EDGES];
  int unsigned   edge_dest [EDGES];
  bit            edge_end  [EDGES];
  int unsigned   edges_used;
  logic [31:0]   hits      [NODES];
  logic [31:0]   hit_peak;
  bit            seen      [NODES];
  int unsigned   walk_node [NODES];
  int unsigned   walk_edge [NODES];
  bit            walk_more [NODES];
  int unsigned   walk_depth;
  bit            small_adj [SMALL_SPAN][SMALL_SPAN];

  int unsigned cycles;
  int          failures;
  int          items_sent;
  int          paths_found;
  int          rejects;
  int          hold_requests;
  int          holds_taken;
  int          stall_left;
  bit          quiet_sender;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void walk_push(int unsigned v);
    if (walk_depth >= NODES || v >= NODES) return;
    walk_node[walk_depth] = v;
    walk_edge[walk_depth] = head_edge[v];
    walk_more[walk_depth] = list_live[v];
    seen[v] = 1'b1;
    walk_depth++;
  endfunction

  // Depth-first search over simple paths; bumps the counters on a hit.
  function automatic int unsigned count_path(int unsigned from, int unsigned to);
    int unsigned top;
    int unsigned u;
    int unsigned e;
    int unsigned t;
    for (int i = 0; i < NODES; i++) seen[i] = 1'b0;
    walk_depth = 0;
    walk_push(from);
    while (walk_depth > 0) begin
      top = walk_depth - 1;
      u = walk_node[top];
      if (u == to) begin
        for (int i = 0; i < walk_depth; i++) begin
          if (hits[walk_node[i]] != 32'hFFFF_FFFF) hits[walk_node[i]]++;
          if (hits[walk_node[i]] > hit_peak) hit_peak = hits[walk_node[i]];
        end
        return walk_depth;
      end
      if (!walk_more[top]) begin
        seen[u] = 1'b0;
        walk_depth--;
        continue;
      end
      while (walk_more[top]) begin
        e = walk_edge[top];
        if (e >= EDGES) begin
          walk_more[top] = 1'b0;
          break;
        end
        t = edge_dest[e];
        walk_more[top] = !edge_end[e];
        walk_edge[top] = next_edge[e];
        if (t < NODES && !seen[t]) begin
          walk_push(t);
          break;
        end
      end
    end
    return 0;
  endfunction

  function automatic answer_t graph_step(logic [1:0] kind, int unsigned a, int unsigned b);
    answer_t r;
    int unsigned n;
    int unsigned e;
    n = (node_limit > NODES) ? NODES : node_limit;
    r.path_length = '0;
    r.error = 1'b0;
    if (kind == KIND_ADD || kind == KIND_QUERY) begin
      if (a >= n || b >= n) begin
        r.error = 1'b1;
      end else if (kind == KIND_ADD) begin
        if (edges_used >= EDGES) begin
          r.error = 1'b1;
        end else begin
          e = edges_used;
          edge_dest[e] = b;
          edge_end[e] = 1'b1;
          next_edge[e] = 0;
          if (list_live[a]) begin
            next_edge[tail_edge[a]] = e;
            edge_end[tail_edge[a]] = 1'b0;
          end else begin
            head_edge[a] = e;
            list_live[a] = 1'b1;
          end
          tail_edge[a] = e;
          edges_used++;
          if (a < SMALL_SPAN && b < SMALL_SPAN) small_adj[a][b] = 1'b1;
        end
      end else begin
        r.path_length = PlenW'(count_path(a, b));
      end
    end
    r.max_count = hit_peak;
    return r;
  endfunction

  // Gap before the next offer: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one transaction; valid stays high afterwards until the caller moves on.
  task automatic offer(logic [1:0] kind, int unsigned a, int unsigned b,
                       bit typed, answer_t typed_answer);
    answer_t got;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, b[9:0], a[9:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = graph_step(kind, a, b);
    if (got.path_length != 0) paths_found++;
    if (got.error) rejects++;
    answer_q.insert(answer_q.size(), typed ? typed_answer : got);
    items_sent++;
  endtask

  task automatic offer_checked(logic [1:0] kind, int unsigned a, int unsigned b);
    answer_t unused;
    unused = '{default: '0};
    offer(kind, a, b, 1'b0, unused);
  endtask

  // Stop offering and let every result come back before touching the register.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_node_count(int unsigned value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value[10:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    node_limit = value;
  endtask

  // One random transaction; most land in the small graph so searches stay short.
  task automatic random_item();
    int r;
    int unsigned n;
    int unsigned span;
    int unsigned a;
    int unsigned b;
    n = (node_limit > NODES) ? NODES : node_limit;
    span = (n < SMALL_SPAN) ? ((n == 0) ? 1 : n) : SMALL_SPAN;
    r = $urandom_range(99);
    if (r < 35) begin
      a = $urandom_range(span - 1);
      b = $urandom_range(span - 1);
      if (a < SMALL_SPAN && b < SMALL_SPAN && small_adj[a][b])
        offer_checked(KIND_REPORT, a, b);
      else
        offer_checked(KIND_ADD, a, b);
    end else if (r < 70) begin
      offer_checked(KIND_QUERY, $urandom_range(span - 1), $urandom_range(span - 1));
    end else if (r < 80) begin
      offer_checked(2'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023));
    end else if (r < 88) begin
      offer_checked(2'($urandom_range(3, 2)), $urandom_range(1023), $urandom_range(1023));
    end else begin
      // Wide nodes: isolated or only linked among themselves.
      a = $urandom_range(1023, SMALL_SPAN);
      b = $urandom_range(1023, SMALL_SPAN);
      offer_checked(2'($urandom_range(1)), a, b);
    end
  endtask

  // Cycle count and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold on request, and checking.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      holds_taken <= 0;
    end else begin
      if (holds_taken != hold_requests) begin
        holds_taken <= hold_requests;
        stall_left <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < 20) begin
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          failures++;
        end else begin
          want = answer_q.pop_front();
          if (out_tdata[31:0] !== want.max_count) begin
            $error("max_count: expected %0d, got %0d", want.max_count, out_tdata[31:0]);
            failures++;
          end
          if (out_tdata[42:32] !== want.path_length) begin
            $error("path_length: expected %0d, got %0d", want.path_length, out_tdata[42:32]);
            failures++;
          end
          if (out_tdata[43] !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, out_tdata[43]);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    answer_t typed_answer;
    int unsigned phase_counts[$];
    cycles = 0;
    failures = 0;
    items_sent = 0;
    paths_found = 0;
    rejects = 0;
    hold_requests = 0;
    quiet_sender = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    node_limit = NODES;
    edges_used = 0;
    hit_peak = '0;
    walk_depth = 0;
    for (int i = 0; i < NODES; i++) begin
      head_edge[i] = 0;
      tail_edge[i] = 0;
      list_live[i] = 1'b0;
      hits[i] = '0;
      seen[i] = 1'b0;
    end
    for (int i = 0; i < EDGES; i++) begin
      next_edge[i] = 0;
      edge_dest[i] = 0;
      edge_end[i] = 1'b0;
    end
    for (int i = 0; i < SMALL_SPAN; i++)
      for (int j = 0; j < SMALL_SPAN; j++) small_adj[i][j] = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: fresh state, start equal to end, no path, cycles,
    // out-of-range nodes, a lowered node count, zero and oversized counts.
    rows = '{
      '{-1, KIND_REPORT, 0, 0, 1, 0, 0, 0},
      '{-1, KIND_SPARE, 1023, 1023, 1, 0, 0, 0},
      '{-1, KIND_QUERY, 0, 0, 1, 1, 1, 0},
      '{-1, KIND_QUERY, 0, 1, 1, 1, 0, 0},
      '{-1, KIND_ADD, 0, 1, 1, 1, 0, 0},
      '{-1, KIND_ADD, 1, 2, 1, 1, 0, 0},
      '{-1, KIND_QUERY, 0, 2, 1, 2, 3, 0},
      '{-1, KIND_ADD, 1023, 1022, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 1023, 1022, 0, 0, 0, 0},
      '{-1, KIND_ADD, 2, 0, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 1, 0, 0, 0, 0, 0},
      '{-1, KIND_ADD, 1, 3, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 0, 3, 0, 0, 0, 0},
      '{4, KIND_ADD, 4, 0, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 0, 1023, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 2, 3, 0, 0, 0, 0},
      '{3, KIND_QUERY, 0, 2, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 2, 3, 0, 0, 0, 0},
      '{0, KIND_ADD, 0, 0, 0, 0, 0, 0},
      '{-1, KIND_QUERY, 0, 0, 0, 0, 0, 0},
      '{-1, KIND_REPORT, 0, 0, 0, 0, 0, 0},
      '{1, KIND_QUERY, 0, 0, 0, 0, 0, 0},
      '{2047, KIND_QUERY, 1023, 1023, 0, 0, 0, 0},
      '{-1, KIND_ADD, 1023, 0, 0, 0, 0, 0}
    };
    foreach (rows[i]) begin
      if (rows[i].cfg >= 0) begin
        drain();
        write_node_count(rows[i].cfg);
      end
      typed_answer.max_count = CountW'(rows[i].max_count);
      typed_answer.path_length = PlenW'(rows[i].path_length);
      typed_answer.error = 1'(rows[i].error);
      offer(2'(rows[i].kind), rows[i].a, rows[i].b, rows[i].typed, typed_answer);
    end

    // Random part across several node counts, extremes included.
    phase_counts = '{6, 1024, 1, 5, 2047, 0, 4, 6};
    foreach (phase_counts[p]) begin
      drain();
      write_node_count(phase_counts[p]);
      quiet_sender = (p == 2);
      if (p == 1) hold_requests++;
      for (int k = 0; k < 14; k++) random_item();
    end
    quiet_sender = 1'b0;

    // A last query and report on the small graph.
    offer_checked(KIND_QUERY, 0, 3);
    offer_checked(KIND_REPORT, 0, 0);

    drain();
    $display("Sent %0d transactions over %0d node-count settings, with a long result stall.",
             items_sent, phase_counts.size() + 5);
    $display("Queries that found a path: %0d, rejected transactions: %0d.",
             paths_found, rejects);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
